/* src/koppen_extended_classifier_assert.svh */
// Assertion macros used by the climate classifier RTL.
`ifndef KOPPEN_EXTENDED_CLASSIFIER_ASSERT_SVH
`define KOPPEN_EXTENDED_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define KEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset
`define KEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define KEC_ASSERT_NOW(label, clk, rst, ante, cons)
`define KEC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/kec_pkg.sv */
// Shared types, class codes and the missing-data reset threshold of the climate classifier.
`default_nettype none

package kec_pkg;

   // Class code
   typedef logic [4:0] class_type;

   localparam class_type CLASS_NONE              = 5'd0;
   localparam class_type CLASS_BSH               = 5'd1;
   localparam class_type CLASS_BSS               = 5'd2;
   localparam class_type CLASS_BSW               = 5'd3;
   localparam class_type CLASS_BSK               = 5'd4;
   localparam class_type CLASS_BWH               = 5'd5;
   localparam class_type CLASS_BWS               = 5'd6;
   localparam class_type CLASS_BWW               = 5'd7;
   localparam class_type CLASS_BWK               = 5'd8;
   localparam class_type CLASS_RAINFOREST        = 5'd9;
   localparam class_type CLASS_AM                = 5'd10;
   localparam class_type CLASS_AS                = 5'd11;
   localparam class_type CLASS_AI                = 5'd12;
   localparam class_type CLASS_SAVANNA           = 5'd13;
   localparam class_type CLASS_CSA               = 5'd14;
   localparam class_type CLASS_CSB               = 5'd15;
   localparam class_type CLASS_CWA               = 5'd16;
   localparam class_type CLASS_CWB               = 5'd17;
   localparam class_type CLASS_CFA               = 5'd18;
   localparam class_type CLASS_CFB               = 5'd19;
   localparam class_type CLASS_CONT_DRYWIN_XCOLD = 5'd20;
   localparam class_type CLASS_CONT_DRYWIN       = 5'd21;
   localparam class_type CLASS_CONT_HUMID_XCOLD  = 5'd22;
   localparam class_type CLASS_CONT_HUMID        = 5'd23;
   localparam class_type CLASS_TUNDRA            = 5'd24;
   localparam class_type CLASS_ICECAP            = 5'd25;

   // Missing-data threshold after reset, tenths of a degree
   localparam logic signed [15:0] MISSING_RESET = -16'sd9990;

   // Input beat
   typedef struct packed {
      logic signed [15:0] temp_mean;
      logic signed [15:0] temp_coldest;
      logic signed [15:0] temp_warmest;
      logic [17:0]        rain_annual;
      logic [17:0]        rain_winter;
      logic [17:0]        rain_summer;
      logic [17:0]        rain_mean;
      logic [17:0]        rain_driest;
      logic [17:0]        rain_winter_max;
      logic [17:0]        rain_winter_min;
      logic [17:0]        rain_summer_max;
      logic [17:0]        rain_summer_min;
   } req_item_type;

   // Result beat
   typedef struct packed {
      class_type climate_class;
   } rsp_item_type;

endpackage

`default_nettype wire

/* src/kec_req_if.sv */
// Input channel of the climate classifier: valid/ready plus one cell beat.
`default_nettype none

interface kec_req_if;
   logic                  valid;
   logic                  ready;
   kec_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/kec_rsp_if.sv */
// Result channel of the climate classifier: valid/ready plus one class beat.
`default_nettype none

interface kec_rsp_if;
   logic                  valid;
   logic                  ready;
   kec_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/kec_classify.sv */
// Decision logic: maps one registered cell beat to its climate class code.
`default_nettype none

module kec_classify (
   input  kec_pkg::req_item_type   item,
   input  logic signed [15:0]      missing_threshold,
   output kec_pkg::class_type      climate_class
);

   // Seasonal wetness: 10*seasonal > 7*annual
   logic [21:0] winter_x10;
   logic [21:0] summer_x10;
   logic [21:0] annual_x7;
   logic        wet_winter;
   logic        wet_summer;

   assign winter_x10 = 22'(item.rain_winter) * 22'd10;
   assign summer_x10 = 22'(item.rain_summer) * 22'd10;
   assign annual_x7  = 22'(item.rain_annual) * 22'd7;
   assign wet_winter = winter_x10 > annual_x7;
   assign wet_summer = summer_x10 > annual_x7;

   // Dryness limits for all three seasonal cases, compared in parallel
   logic signed [21:0] dry_base;
   logic signed [21:0] dry_summer;
   logic signed [21:0] dry_even;
   logic signed [21:0] rain_avg_s;
   logic signed [21:0] rain_avg2_s;
   logic               arid_base, arid_summer, arid_even;
   logic               steppe_base, steppe_summer, steppe_even;
   logic               arid;
   logic               steppe;

   assign dry_base    = $signed({{5{item.temp_mean[15]}}, item.temp_mean, 1'b0});
   assign dry_summer  = dry_base + 22'sd280;
   assign dry_even    = dry_base + 22'sd140;
   assign rain_avg_s  = $signed({4'b0000, item.rain_mean});
   assign rain_avg2_s = $signed({3'b000, item.rain_mean, 1'b0});

   assign arid_base     = rain_avg_s <= dry_base;
   assign arid_summer   = rain_avg_s <= dry_summer;
   assign arid_even     = rain_avg_s <= dry_even;
   assign steppe_base   = rain_avg2_s >= dry_base;
   assign steppe_summer = rain_avg2_s >= dry_summer;
   assign steppe_even   = rain_avg2_s >= dry_even;

   assign arid   = wet_winter ? arid_base   : (wet_summer ? arid_summer   : arid_even);
   assign steppe = wet_winter ? steppe_base : (wet_summer ? steppe_summer : steppe_even);

   // Monthly rain products
   logic [19:0] wmax_x3;
   logic [19:0] smax_x3;
   logic [19:0] smin_x3;
   logic [21:0] wmin_x10;
   logic [28:0] monsoon_sum;
   logic        summer_dry_b;
   logic        winter_dry_b;
   logic        monsoon;
   logic        summer_wet_c;

   assign wmax_x3      = 20'(item.rain_winter_max) * 20'd3;
   assign smax_x3      = 20'(item.rain_summer_max) * 20'd3;
   assign smin_x3      = 20'(item.rain_summer_min) * 20'd3;
   assign wmin_x10     = 22'(item.rain_winter_min) * 22'd10;
   assign monsoon_sum  = 29'(item.rain_driest) * 29'd635 + 29'(item.rain_annual);
   assign summer_dry_b = 20'(item.rain_summer_max) > wmax_x3;
   assign winter_dry_b = 20'(item.rain_winter_max) > smax_x3;
   assign monsoon      = monsoon_sum > 29'd25019;
   assign summer_wet_c = 22'(item.rain_summer_max) >= wmin_x10;

   // Annual temperature range
   logic signed [16:0] temp_span;

   assign temp_span = $signed({item.temp_warmest[15], item.temp_warmest})
                    - $signed({item.temp_coldest[15], item.temp_coldest});

   // Class selection, first matching group wins
   always_comb begin
      climate_class = kec_pkg::CLASS_NONE;
      priority if (item.temp_mean <= missing_threshold) begin
         climate_class = kec_pkg::CLASS_NONE;
      end else if (arid) begin
         priority if (item.temp_mean > 16'sd180) begin
            climate_class = steppe ? kec_pkg::CLASS_BSH : kec_pkg::CLASS_BWH;
         end else if (summer_dry_b) begin
            climate_class = steppe ? kec_pkg::CLASS_BSS : kec_pkg::CLASS_BWS;
         end else if (winter_dry_b) begin
            climate_class = steppe ? kec_pkg::CLASS_BSW : kec_pkg::CLASS_BWW;
         end else begin
            climate_class = steppe ? kec_pkg::CLASS_BSK : kec_pkg::CLASS_BWK;
         end
      end else if (item.temp_coldest >= 16'sd180) begin
         priority if (item.rain_driest >= 18'd60) begin
            climate_class = kec_pkg::CLASS_RAINFOREST;
         end else if (monsoon) begin
            climate_class = kec_pkg::CLASS_AM;
         end else if (item.rain_summer_min < 18'd60) begin
            climate_class = kec_pkg::CLASS_AS;
         end else if (temp_span < 17'sd50) begin
            climate_class = kec_pkg::CLASS_AI;
         end else begin
            climate_class = kec_pkg::CLASS_SAVANNA;
         end
      end else if (item.temp_coldest >= -16'sd30 && item.temp_warmest > 16'sd100) begin
         // hot summer (a) above 22.0 degrees
         priority if (20'(item.rain_winter_max) >= smin_x3) begin
            climate_class = (item.temp_warmest > 16'sd220) ?
                            kec_pkg::CLASS_CSA : kec_pkg::CLASS_CSB;
         end else if (summer_wet_c) begin
            climate_class = (item.temp_warmest > 16'sd220) ?
                            kec_pkg::CLASS_CWA : kec_pkg::CLASS_CWB;
         end else begin
            climate_class = (item.temp_warmest > 16'sd220) ?
                            kec_pkg::CLASS_CFA : kec_pkg::CLASS_CFB;
         end
      end else if (item.temp_coldest < -16'sd30 && item.temp_warmest >= 16'sd100) begin
         // very cold winter (d) below -38.0 degrees
         if (summer_wet_c) begin
            climate_class = (item.temp_coldest < -16'sd380) ?
                            kec_pkg::CLASS_CONT_DRYWIN_XCOLD : kec_pkg::CLASS_CONT_DRYWIN;
         end else begin
            climate_class = (item.temp_coldest < -16'sd380) ?
                            kec_pkg::CLASS_CONT_HUMID_XCOLD : kec_pkg::CLASS_CONT_HUMID;
         end
      end else if (item.temp_warmest < 16'sd100) begin
         climate_class = (item.temp_warmest >= 16'sd0) ?
                         kec_pkg::CLASS_TUNDRA : kec_pkg::CLASS_ICECAP;
      end else begin
         // no group applies
         climate_class = kec_pkg::CLASS_NONE;
      end
   end

endmodule

`default_nettype wire

/* src/koppen_extended_classifier.sv */
// Climate classifier top level: input stage, decision logic, result stage.
//
// Usage:
//   req_bus carries one grid cell per beat (valid/ready); rsp_bus returns
//   exactly one class code per cell, in order. csr_write_enable with
//   csr_write_data sets the missing-data threshold (signed tenths of a
//   degree); write it only while no cell is in flight.
// Path: an accepted req beat passes the input register, then the class
//   register behind the decision logic, before rsp valid rises.
// Throughput: one cell per cycle; both stages move together whenever the
//   result register is empty or being read in the same cycle.
// Reset: synchronous, active high; clears both stage valids and loads the
//   threshold with -999.0 degrees.
// Stall: while rsp_bus is held off, the result register keeps its beat and
//   the input register still takes one more cell; req ready drops only
//   when both registers are full.
`default_nettype none
`include "koppen_extended_classifier_assert.svh"

module koppen_extended_classifier (
   input  logic               clock,
   input  logic               reset,
   kec_req_if.sink            req_bus,
   kec_rsp_if.source          rsp_bus,
   input  logic               csr_write_enable,
   input  logic signed [15:0] csr_write_data
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   kec_pkg::req_item_type in_item_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   kec_pkg::class_type    out_class_ff;
   logic signed [15:0]    threshold_ff;
   logic signed [15:0]    threshold_in;
   kec_pkg::class_type    class_code;
   logic                  advance;
   logic                  req_take;

   // Stage flow control
   assign advance        = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = !in_valid_ff || advance;
   assign req_take       = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in  = req_bus.ready ? req_bus.valid : in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      threshold_in = csr_write_enable ? csr_write_data : threshold_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         threshold_ff <= kec_pkg::MISSING_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         threshold_ff <= threshold_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_bus.payload;
      end
      if (advance && in_valid_ff) begin
         out_class_ff <= class_code;
      end
   end

   kec_classify u_classify (
      .item              (in_item_ff),
      .missing_threshold (threshold_ff),
      .climate_class     (class_code)
   );

   assign rsp_bus.valid                 = out_valid_ff;
   assign rsp_bus.payload.climate_class = out_class_ff;

   // Checks
   `KEC_ASSERT_NOW(a_full_stall_blocks, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_bus.ready, !req_bus.ready)
   `KEC_ASSERT_NEXT(a_take_fills_stage, clock, reset, req_take, in_valid_ff)
   `KEC_ASSERT_NEXT(a_missing_masked, clock, reset,
      in_valid_ff && advance && (in_item_ff.temp_mean <= threshold_ff),
      out_valid_ff && (out_class_ff == kec_pkg::CLASS_NONE))
   `KEC_ASSERT_NOW(a_class_in_range, clock, reset,
      out_valid_ff, out_class_ff <= kec_pkg::CLASS_ICECAP)

endmodule

`default_nettype wire
